[rtl/core/tws_pkg.sv]
// Shared types, codes and checksum helpers for the two-wire sensor bus master.
// Used by tws_front, tws_seq and the top level under rtl/core; depends on nothing.
package tws_pkg;

	// Build-time defaults
	localparam int RESET_PULSES_DEF = 9;
	localparam int TIMEOUT_BITS_DEF = 24;

	// Register file geometry
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic CFG_IDX_TIMEOUT = 1'b0;
	localparam logic CFG_IDX_PHASE   = 1'b1;
	localparam logic [23:0] TIMEOUT_RST = 24'd10000000;
	localparam logic [7:0]  PHASE_RST   = 8'd1;

	// Modes
	localparam logic [2:0] MODE_TEMP    = 3'd0;
	localparam logic [2:0] MODE_HUMID   = 3'd1;
	localparam logic [2:0] MODE_RD_STAT = 3'd2;
	localparam logic [2:0] MODE_WR_STAT = 3'd3;
	localparam logic [2:0] MODE_SOFT_RST = 3'd4;
	localparam logic [2:0] MODE_CONN_RST = 3'd5;

	// Sensor commands
	localparam logic [7:0] CMD_TEMP     = 8'h03;
	localparam logic [7:0] CMD_HUMID    = 8'h05;
	localparam logic [7:0] CMD_RD_STAT  = 8'h07;
	localparam logic [7:0] CMD_WR_STAT  = 8'h06;
	localparam logic [7:0] CMD_SOFT_RST = 8'h1E;
	localparam logic [7:0] CRC_POLY     = 8'h31;

	// Sequencer phases
	localparam logic [4:0] PS_IDLE  = 5'd0;
	localparam logic [4:0] PS_RLO   = 5'd1;
	localparam logic [4:0] PS_RHI   = 5'd2;
	localparam logic [4:0] PS_S0    = 5'd3;
	localparam logic [4:0] PS_S1    = 5'd4;
	localparam logic [4:0] PS_S2    = 5'd5;
	localparam logic [4:0] PS_S3    = 5'd6;
	localparam logic [4:0] PS_S4    = 5'd7;
	localparam logic [4:0] PS_S5    = 5'd8;
	localparam logic [4:0] PS_S6    = 5'd9;
	localparam logic [4:0] PS_WLO   = 5'd10;
	localparam logic [4:0] PS_WHI   = 5'd11;
	localparam logic [4:0] PS_ALO   = 5'd12;
	localparam logic [4:0] PS_AHI   = 5'd13;
	localparam logic [4:0] PS_WAIT  = 5'd14;
	localparam logic [4:0] PS_DHI   = 5'd15;
	localparam logic [4:0] PS_DLO   = 5'd16;
	localparam logic [4:0] PS_KSET  = 5'd17;
	localparam logic [4:0] PS_KHI   = 5'd18;
	localparam logic [4:0] PS_KHOLD = 5'd19;
	localparam logic [4:0] PS_DONE  = 5'd20;

	// One classified tick as it waits between front and back
	typedef struct packed {
		logic       start_ok;
		logic [2:0] mode;
		logic [7:0] write_value;
		logic       sda_in;
	} tick_t;

	// One result request
	typedef struct packed {
		logic        sck_out;
		logic        sda_release;
		logic        busy_res;
		logic        done_res;
		logic [15:0] data_value;
		logic        ack_error;
		logic        crc_error;
		logic        timeout_error;
	} result_t;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [23:0] timeout_ticks;
		logic [7:0]  phase_ticks;
	} cfg_t;

	// CRC-8, poly 0x31, one byte folded in
	function automatic logic [7:0] crc8_step(input logic [7:0] b, input logic [7:0] c);
		logic [7:0] r;
		r = c ^ b;
		for (int i = 0; i < 8; i++) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

	function automatic logic [7:0] cmd_of(input logic [2:0] m);
		logic [7:0] c;
		unique case (m)
			MODE_TEMP:    c = CMD_TEMP;
			MODE_HUMID:   c = CMD_HUMID;
			MODE_RD_STAT: c = CMD_RD_STAT;
			MODE_WR_STAT: c = CMD_WR_STAT;
			default:      c = CMD_SOFT_RST;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/tws_queue.sv]
// Two-entry flop queue, generic payload width.
// Depends on nothing.
module tws_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)      count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

endmodule

[rtl/core/tws_front.sv]
// Front end: classifies incoming ticks and queues them for the sequencer.
// Depends on tws_pkg and tws_queue.
module tws_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               start_req,
	input  logic [2:0]         mode,
	input  logic [7:0]         write_value,
	input  logic               sda_in,
	input  logic               pop,
	output logic               empty,
	output tws_pkg::tick_t     tick
);

	tws_pkg::tick_t tick_in;

	// A start counts only with a defined mode
	always_comb begin
		tick_in.start_ok    = start_req && (mode <= tws_pkg::MODE_CONN_RST);
		tick_in.mode        = mode;
		tick_in.write_value = write_value;
		tick_in.sda_in      = sda_in;
	end

	tws_queue #(.WIDTH($bits(tws_pkg::tick_t))) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (tick_in),
		.full  (full),
		.pop   (pop),
		.rdata (tick),
		.empty (empty)
	);

endmodule

[rtl/core/tws_seq.sv]
// Back end: bus phase sequencer, one queued tick per step, one result out.
// Depends on tws_pkg.
module tws_seq #(
	parameter int RESET_PULSES = tws_pkg::RESET_PULSES_DEF,
	parameter int TIMEOUT_BITS = tws_pkg::TIMEOUT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tws_pkg::cfg_t    cfg,
	input  logic             in_empty,
	input  tws_pkg::tick_t   tick,
	output logic             in_pop,
	input  logic             out_full,
	output logic             out_push,
	output tws_pkg::result_t res
);

	localparam int CW = (TIMEOUT_BITS > 24) ? TIMEOUT_BITS : 24;
	localparam logic [4:0] PULSES = 5'(RESET_PULSES);

	logic [4:0]              st_q, st_n;
	logic [3:0]              bit_q, bit_n;
	logic [1:0]              byte_q, byte_n;
	logic [7:0]              shift_q, shift_n;
	logic [7:0]              crc_q, crc_n;
	logic [TIMEOUT_BITS-1:0] wait_q, wait_n;
	logic [7:0]              hold_q, hold_n;
	logic [2:0]              mode_q, mode_n;
	logic [15:0]             word_q, word_n;
	logic [2:0]              err_q, err_n;

	logic       take;
	logic [7:0] pt;
	logic       timed;
	logic [1:0] total;
	logic       ack_now;
	logic [3:0] bit_inc;
	logic [7:0] shift_in;
	logic       wait_expired;

	assign take     = !in_empty && !out_full;
	assign in_pop   = take;
	assign out_push = take;

	// Per-step helpers
	always_comb begin
		pt      = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
		timed   = (st_q != tws_pkg::PS_IDLE) && (st_q != tws_pkg::PS_WAIT) &&
			(st_q <= tws_pkg::PS_KHOLD);
		total   = (mode_q == tws_pkg::MODE_RD_STAT) ? 2'd2 : 2'd3;
		ack_now = ({1'b0, byte_q} + 3'd1) < {1'b0, total};
		bit_inc = bit_q + 4'd1;
		shift_in = {shift_q[6:0], tick.sda_in};
		wait_expired = (CW'(wait_q) >= CW'(cfg.timeout_ticks)) ||
			(wait_q == {TIMEOUT_BITS{1'b1}});
	end

	// Bus levels and status from the current phase
	always_comb begin
		res.sck_out     = 1'b0;
		res.sda_release = 1'b1;
		unique case (st_q)
			tws_pkg::PS_RHI, tws_pkg::PS_S1, tws_pkg::PS_S5,
			tws_pkg::PS_AHI, tws_pkg::PS_DHI: res.sck_out = 1'b1;
			tws_pkg::PS_S2, tws_pkg::PS_S4: begin
				res.sck_out     = 1'b1;
				res.sda_release = 1'b0;
			end
			tws_pkg::PS_S3: res.sda_release = 1'b0;
			tws_pkg::PS_WLO: res.sda_release = shift_q[7];
			tws_pkg::PS_WHI: begin
				res.sck_out     = 1'b1;
				res.sda_release = shift_q[7];
			end
			tws_pkg::PS_KSET, tws_pkg::PS_KHOLD: res.sda_release = !ack_now;
			tws_pkg::PS_KHI: begin
				res.sck_out     = 1'b1;
				res.sda_release = !ack_now;
			end
			default: ;
		endcase
		res.busy_res      = (st_q != tws_pkg::PS_IDLE) && (st_q < tws_pkg::PS_DONE);
		res.done_res      = (st_q == tws_pkg::PS_DONE);
		res.data_value    = word_q;
		res.ack_error     = err_q[0];
		res.crc_error     = err_q[1];
		res.timeout_error = err_q[2];
	end

	// Next state
	always_comb begin
		st_n    = st_q;
		bit_n   = bit_q;
		byte_n  = byte_q;
		shift_n = shift_q;
		crc_n   = crc_q;
		wait_n  = wait_q;
		hold_n  = hold_q;
		mode_n  = mode_q;
		word_n  = word_q;
		err_n   = err_q;
		if (timed && ({1'b0, hold_q} + 9'd1 < {1'b0, pt})) begin
			hold_n = hold_q + 8'd1;
		end else begin
			if (timed) hold_n = 8'd0;
			unique case (st_q)
				tws_pkg::PS_RLO: st_n = tws_pkg::PS_RHI;
				tws_pkg::PS_RHI: begin
					if ({1'b0, bit_q} + 5'd1 >= PULSES) begin
						bit_n = 4'd0;
						st_n  = tws_pkg::PS_S0;
					end else begin
						bit_n = bit_inc;
						st_n  = tws_pkg::PS_RLO;
					end
				end
				tws_pkg::PS_S0, tws_pkg::PS_S1, tws_pkg::PS_S2,
				tws_pkg::PS_S3, tws_pkg::PS_S4, tws_pkg::PS_S5: st_n = st_q + 5'd1;
				tws_pkg::PS_S6: begin
					if (mode_q == tws_pkg::MODE_CONN_RST) begin
						st_n = tws_pkg::PS_DONE;
					end else begin
						shift_n = tws_pkg::cmd_of(mode_q);
						crc_n   = tws_pkg::crc8_step(tws_pkg::cmd_of(mode_q), 8'd0);
						bit_n   = 4'd0;
						st_n    = tws_pkg::PS_WLO;
					end
				end
				tws_pkg::PS_WLO: st_n = tws_pkg::PS_WHI;
				tws_pkg::PS_WHI: begin
					shift_n = {shift_q[6:0], 1'b0};
					bit_n   = bit_inc;
					st_n    = (bit_inc >= 4'd8) ? tws_pkg::PS_ALO : tws_pkg::PS_WLO;
				end
				tws_pkg::PS_ALO: st_n = tws_pkg::PS_AHI;
				tws_pkg::PS_AHI: begin
					if (tick.sda_in) err_n[0] = 1'b1;
					bit_n = 4'd0;
					if (mode_q <= tws_pkg::MODE_HUMID) begin
						wait_n = '0;
						st_n   = tws_pkg::PS_WAIT;
					end else if (mode_q == tws_pkg::MODE_RD_STAT) begin
						shift_n = 8'd0;
						st_n    = tws_pkg::PS_DHI;
					end else if (mode_q == tws_pkg::MODE_WR_STAT && byte_q == 2'd0) begin
						byte_n  = 2'd1;
						shift_n = word_q[7:0];
						st_n    = tws_pkg::PS_WLO;
					end else begin
						st_n = tws_pkg::PS_DONE;
					end
				end
				tws_pkg::PS_WAIT: begin
					if (!tick.sda_in) begin
						bit_n   = 4'd0;
						shift_n = 8'd0;
						st_n    = tws_pkg::PS_DHI;
					end else if (wait_expired) begin
						err_n[2] = 1'b1;
						st_n     = tws_pkg::PS_DONE;
					end else begin
						wait_n = wait_q + 1'b1;
					end
				end
				tws_pkg::PS_DHI: begin
					shift_n = shift_in;
					bit_n   = bit_inc;
					st_n    = tws_pkg::PS_DLO;
				end
				tws_pkg::PS_DLO: begin
					if (bit_q < 4'd8) begin
						st_n = tws_pkg::PS_DHI;
					end else begin
						if (!ack_now) begin
							// last byte is the checksum
							if (tws_pkg::rev8(crc_q) != shift_q) err_n[1] = 1'b1;
						end else begin
							crc_n = tws_pkg::crc8_step(shift_q, crc_q);
							if (mode_q == tws_pkg::MODE_RD_STAT) word_n = {8'd0, shift_q};
							else if (byte_q == 2'd0)             word_n = {shift_q, 8'd0};
							else                                 word_n = {word_q[15:8], shift_q};
						end
						st_n = tws_pkg::PS_KSET;
					end
				end
				tws_pkg::PS_KSET: st_n = tws_pkg::PS_KHI;
				tws_pkg::PS_KHI:  st_n = tws_pkg::PS_KHOLD;
				tws_pkg::PS_KHOLD: begin
					byte_n = byte_q + 2'd1;
					if ((byte_q + 2'd1) < total) begin
						bit_n   = 4'd0;
						shift_n = 8'd0;
						st_n    = tws_pkg::PS_DHI;
					end else begin
						st_n = tws_pkg::PS_DONE;
					end
				end
				tws_pkg::PS_IDLE: begin
					if (tick.start_ok) begin
						mode_n  = tick.mode;
						err_n   = 3'd0;
						crc_n   = 8'd0;
						bit_n   = 4'd0;
						byte_n  = 2'd0;
						shift_n = 8'd0;
						wait_n  = '0;
						hold_n  = 8'd0;
						word_n  = (tick.mode == tws_pkg::MODE_WR_STAT) ?
							{8'd0, tick.write_value} : 16'd0;
						st_n    = (tick.mode >= tws_pkg::MODE_SOFT_RST) ?
							tws_pkg::PS_RLO : tws_pkg::PS_S0;
					end
				end
				default: begin
					// done tick and any stray code fall back to idle
					st_n   = tws_pkg::PS_IDLE;
					hold_n = 8'd0;
				end
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= tws_pkg::PS_IDLE;
			bit_q   <= 4'd0;
			byte_q  <= 2'd0;
			shift_q <= 8'd0;
			crc_q   <= 8'd0;
			wait_q  <= '0;
			hold_q  <= 8'd0;
			mode_q  <= 3'd0;
			word_q  <= 16'd0;
			err_q   <= 3'd0;
		end else if (take) begin
			st_q    <= st_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			crc_q   <= crc_n;
			wait_q  <= wait_n;
			hold_q  <= hold_n;
			mode_q  <= mode_n;
			word_q  <= word_n;
			err_q   <= err_n;
		end
	end

	// Checks
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && st_q == tws_pkg::PS_DONE |=> st_q == tws_pkg::PS_IDLE)
		else $error("done phase did not return to idle");
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= 2'd3 && (st_q != tws_pkg::PS_DHI || byte_q < total))
		else $error("read byte count out of range");
	a_write_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tws_pkg::PS_WLO || st_q == tws_pkg::PS_WHI) |-> bit_q < 4'd8)
		else $error("write bit count overran");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(st_q) && $stable(hold_q))
		else $error("sequencer moved without a request");

endmodule

[rtl/core/two_wire_sensor_bus_master.sv]
// Top level of the two-wire sensor bus master: register port, front queue,
// sequencer and result queue. Depends on tws_pkg, tws_front, tws_seq, tws_queue.
//
// Usage: each pushed request is one tick of the bus timeline, carrying the
// start request, mode, status byte to write and the sampled data line. Every
// tick yields exactly one result request (clock level, data release, busy,
// done, data word and error flags), popped in order from the result side.
// Throughput: one tick per clock; the sequencer steps whenever a tick waits
// and the two-entry result queue has room. A tick is first held in the front
// queue; its result is then registered in the result queue.
// If the receiver stalls, results collect in the result queue, the sequencer
// holds its state and the front queue fills; full rises after two more
// ticks. No tick is dropped. Reset clears both queues and puts the sequencer
// in idle with all counters and flags zero; timeout_ticks returns to
// 10000000 and phase_ticks to 1. Registers: timeout_ticks at 0x0, phase_ticks
// at 0x4; write them only while the block is idle.
module two_wire_sensor_bus_master #(
	parameter int RESET_PULSES = tws_pkg::RESET_PULSES_DEF,
	parameter int TIMEOUT_BITS = tws_pkg::TIMEOUT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tws_pkg::CFG_AW-1:0] paddr,
	input  logic [tws_pkg::CFG_DW-1:0] pwdata,
	output logic [tws_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	// tick side
	input  logic                       push,
	output logic                       full,
	input  logic                       start_req,
	input  logic [2:0]                 mode,
	input  logic [7:0]                 write_value,
	input  logic                       sda_in,
	// result side
	input  logic                       pop,
	output logic                       empty,
	output logic                       sck_out,
	output logic                       sda_release,
	output logic                       busy_res,
	output logic                       done_res,
	output logic [15:0]                data_value,
	output logic                       ack_error,
	output logic                       crc_error,
	output logic                       timeout_error
);

	logic [23:0]      timeout_q;
	logic [7:0]       phase_q;
	logic             reg_idx;
	tws_pkg::cfg_t    cfg;
	tws_pkg::tick_t   tick;
	tws_pkg::result_t res;
	tws_pkg::result_t res_out;
	logic             tick_empty;
	logic             tick_pop;
	logic             res_full;
	logic             res_push;

	// Register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign prdata  = (reg_idx == tws_pkg::CFG_IDX_PHASE) ?
		{24'd0, phase_q} : {8'd0, timeout_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= tws_pkg::TIMEOUT_RST;
			phase_q   <= tws_pkg::PHASE_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				tws_pkg::CFG_IDX_TIMEOUT: timeout_q <= pwdata[23:0];
				tws_pkg::CFG_IDX_PHASE:   phase_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.timeout_ticks = timeout_q;
	assign cfg.phase_ticks   = phase_q;

	tws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.start_req  (start_req),
		.mode       (mode),
		.write_value(write_value),
		.sda_in     (sda_in),
		.pop        (tick_pop),
		.empty      (tick_empty),
		.tick       (tick)
	);

	tws_seq #(
		.RESET_PULSES(RESET_PULSES),
		.TIMEOUT_BITS(TIMEOUT_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_empty(tick_empty),
		.tick    (tick),
		.in_pop  (tick_pop),
		.out_full(res_full),
		.out_push(res_push),
		.res     (res)
	);

	tws_queue #(.WIDTH($bits(tws_pkg::result_t))) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign sck_out       = res_out.sck_out;
	assign sda_release   = res_out.sda_release;
	assign busy_res      = res_out.busy_res;
	assign done_res      = res_out.done_res;
	assign data_value    = res_out.data_value;
	assign ack_error     = res_out.ack_error;
	assign crc_error     = res_out.crc_error;
	assign timeout_error = res_out.timeout_error;

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for two_wire_sensor_bus_master: queue-driven ticks, a
// tick-level predictor of the bus sequencer and an in-order result check.
// Depends on tws_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_top;
	import tws_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int HOLD_CYCLES    = 300;

	// One bus tick as offered on the request side
	typedef struct packed {
		logic       start_req;
		logic [2:0] mode;
		logic [7:0] write_value;
		logic       sda_in;
	} tick_item_t;

	// Sequencer state as tracked by the predictor
	typedef struct packed {
		logic [4:0]  ps;
		logic [3:0]  bit_cnt;
		logic [1:0]  byte_cnt;
		logic [7:0]  shreg;
		logic [7:0]  crc;
		logic [23:0] wait_cnt;
		logic [7:0]  hold_cnt;
		logic [2:0]  lmode;
		logic [15:0] rword;
		logic [2:0]  eflags;
	} bus_state_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata, prdata;
	logic        pready;
	logic        push, full, pop, empty;
	tick_item_t  drv;
	result_t     res;

	tick_item_t  pending_ticks[$];
	result_t     expected_bus[$];
	bus_state_t  track_st, gen_st;
	logic [23:0] tmo_cfg, gen_tmo;
	logic [7:0]  pt_cfg, gen_pt;
	int          idle_mode;
	bit          hold_req, hold_used;
	bit          in_taken;
	int          hold_left;
	int          errors, watchdog, ticks_made, txns_made, results_seen;

	two_wire_sensor_bus_master DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .start_req(drv.start_req), .mode(drv.mode),
		.write_value(drv.write_value), .sda_in(drv.sda_in),
		.pop(pop), .empty(empty), .sck_out(res.sck_out), .sda_release(res.sda_release),
		.busy_res(res.busy_res), .done_res(res.done_res), .data_value(res.data_value),
		.ack_error(res.ack_error), .crc_error(res.crc_error),
		.timeout_error(res.timeout_error)
	);

	// Clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [7:0] crc31_fold(input logic [7:0] b, input logic [7:0] c);
		logic [7:0] r;
		r = c ^ b;
		for (int i = 0; i < 8; i++) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ 8'h31) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [7:0] bit_mirror(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[i] = v[7 - i];
		return r;
	endfunction

	function automatic logic [7:0] sensor_cmd(input logic [2:0] m);
		case (m)
			MODE_TEMP:    return CMD_TEMP;
			MODE_HUMID:   return CMD_HUMID;
			MODE_RD_STAT: return CMD_RD_STAT;
			MODE_WR_STAT: return CMD_WR_STAT;
			default:      return CMD_SOFT_RST;
		endcase
	endfunction

	// One sequencer tick: output from the current state, then the update
	function automatic result_t bus_tick(inout bus_state_t st, input logic [23:0] tmo,
			input logic [7:0] ptk, input tick_item_t t);
		result_t r;
		int      total, pt;
		logic    ack_now;
		r = '0;
		r.sda_release = 1'b1;
		total = (st.lmode == MODE_RD_STAT) ? 2 : 3;
		pt = (ptk == 8'd0) ? 1 : int'(ptk);
		ack_now = (st.byte_cnt + 1 < total);
		case (st.ps)
			PS_RHI, PS_S1, PS_S5, PS_AHI, PS_DHI: r.sck_out = 1'b1;
			PS_S2, PS_S4: begin
				r.sck_out = 1'b1;
				r.sda_release = 1'b0;
			end
			PS_S3: r.sda_release = 1'b0;
			PS_WLO: r.sda_release = st.shreg[7];
			PS_WHI: begin
				r.sck_out = 1'b1;
				r.sda_release = st.shreg[7];
			end
			PS_KSET, PS_KHOLD: r.sda_release = !ack_now;
			PS_KHI: begin
				r.sck_out = 1'b1;
				r.sda_release = !ack_now;
			end
			default: ;
		endcase
		r.busy_res = (st.ps != PS_IDLE && st.ps != PS_DONE && st.ps <= PS_DONE);
		r.done_res = (st.ps == PS_DONE);
		r.data_value = st.rword;
		r.ack_error = st.eflags[0];
		r.crc_error = st.eflags[1];
		r.timeout_error = st.eflags[2];
		// phase hold
		if (st.ps != PS_IDLE && st.ps != PS_WAIT && st.ps != PS_DONE && st.ps <= PS_KHOLD) begin
			if (st.hold_cnt + 1 < pt) begin
				st.hold_cnt = st.hold_cnt + 8'd1;
				return r;
			end
			st.hold_cnt = '0;
		end
		case (st.ps)
			PS_RLO: st.ps = PS_RHI;
			PS_RHI: begin
				if (st.bit_cnt + 1 >= RESET_PULSES_DEF) begin
					st.bit_cnt = '0;
					st.ps = PS_S0;
				end else begin
					st.bit_cnt = st.bit_cnt + 4'd1;
					st.ps = PS_RLO;
				end
			end
			PS_S0, PS_S1, PS_S2, PS_S3, PS_S4, PS_S5: st.ps = st.ps + 5'd1;
			PS_S6: begin
				if (st.lmode == MODE_CONN_RST) st.ps = PS_DONE;
				else begin
					st.shreg = sensor_cmd(st.lmode);
					st.crc = crc31_fold(st.shreg, 8'h00);
					st.bit_cnt = '0;
					st.ps = PS_WLO;
				end
			end
			PS_WLO: st.ps = PS_WHI;
			PS_WHI: begin
				st.shreg = {st.shreg[6:0], 1'b0};
				st.bit_cnt = st.bit_cnt + 4'd1;
				st.ps = (st.bit_cnt >= 4'd8) ? PS_ALO : PS_WLO;
			end
			PS_ALO: st.ps = PS_AHI;
			PS_AHI: begin
				if (t.sda_in) st.eflags[0] = 1'b1;
				st.bit_cnt = '0;
				if (st.lmode <= MODE_HUMID) begin
					st.wait_cnt = '0;
					st.ps = PS_WAIT;
				end else if (st.lmode == MODE_RD_STAT) begin
					st.shreg = '0;
					st.ps = PS_DHI;
				end else if (st.lmode == MODE_WR_STAT && st.byte_cnt == 2'd0) begin
					st.byte_cnt = 2'd1;
					st.shreg = st.rword[7:0];
					st.ps = PS_WLO;
				end else st.ps = PS_DONE;
			end
			PS_WAIT: begin
				if (!t.sda_in) begin
					st.bit_cnt = '0;
					st.shreg = '0;
					st.ps = PS_DHI;
				end else if (st.wait_cnt >= tmo || st.wait_cnt == 24'hFFFFFF) begin
					st.eflags[2] = 1'b1;
					st.ps = PS_DONE;
				end else st.wait_cnt = st.wait_cnt + 24'd1;
			end
			PS_DHI: begin
				st.shreg = {st.shreg[6:0], t.sda_in};
				st.bit_cnt = st.bit_cnt + 4'd1;
				st.ps = PS_DLO;
			end
			PS_DLO: begin
				if (st.bit_cnt < 4'd8) st.ps = PS_DHI;
				else begin
					if (st.byte_cnt + 1 >= total) begin
						if (bit_mirror(st.crc) != st.shreg) st.eflags[1] = 1'b1;
					end else begin
						st.crc = crc31_fold(st.shreg, st.crc);
						if (st.lmode == MODE_RD_STAT) st.rword = {8'h00, st.shreg};
						else if (st.byte_cnt == 2'd0) st.rword = {st.shreg, 8'h00};
						else st.rword[7:0] = st.shreg;
					end
					st.ps = PS_KSET;
				end
			end
			PS_KSET: st.ps = PS_KHI;
			PS_KHI: st.ps = PS_KHOLD;
			PS_KHOLD: begin
				st.byte_cnt = st.byte_cnt + 2'd1;
				if (st.byte_cnt < total) begin
					st.bit_cnt = '0;
					st.shreg = '0;
					st.ps = PS_DHI;
				end else st.ps = PS_DONE;
			end
			PS_IDLE: begin
				if (t.start_req && t.mode <= MODE_CONN_RST) begin
					st = '0;
					st.lmode = t.mode;
					st.rword = (t.mode == MODE_WR_STAT) ? {8'h00, t.write_value} : 16'h0;
					st.ps = (t.mode >= MODE_SOFT_RST) ? PS_RLO : PS_S0;
				end
			end
			default: begin
				st.ps = PS_IDLE;
				st.hold_cnt = '0;
			end
		endcase
		return r;
	endfunction

	// Append one tick, stepping the generator's own copy of the sequencer
	task automatic add_tick(input tick_item_t t);
		result_t dummy;
		dummy = bus_tick(gen_st, gen_tmo, gen_pt, t);
		pending_ticks.push_back(t);
		ticks_made++;
	endtask

	// One transaction: drives sda like a sensor would, with optional faults
	task automatic run_txn(input logic [2:0] m, input logic [7:0] wv, input bit nack,
			input bit bad_crc, input bit long_wait);
		tick_item_t t;
		logic [7:0] rd_byte;
		int         total;
		rd_byte = 8'h00;
		total = (m == MODE_RD_STAT) ? 2 : 3;
		t = '{1'b1, m, wv, 1'($urandom_range(0, 1))};
		add_tick(t);
		txns_made++;
		while (gen_st.ps != PS_IDLE) begin
			// start noise while busy must be ignored
			t.start_req = ($urandom_range(0, 9) < 3);
			t.mode = 3'($urandom_range(0, 7));
			t.write_value = 8'($urandom);
			t.sda_in = 1'($urandom_range(0, 1));
			case (gen_st.ps)
				PS_AHI: t.sda_in = nack ? 1'b1 : ($urandom_range(0, 19) == 0);
				PS_WAIT: t.sda_in = long_wait ? 1'b1 : ($urandom_range(0, 5) != 0);
				PS_DHI: begin
					if (gen_st.bit_cnt == 4'd0 && gen_st.hold_cnt == 8'd0) begin
						if (gen_st.byte_cnt + 1 >= total && !bad_crc &&
								$urandom_range(0, 9) != 0)
							rd_byte = bit_mirror(gen_st.crc);
						else rd_byte = 8'($urandom);
					end
					t.sda_in = rd_byte[7 - gen_st.bit_cnt];
				end
				default: ;
			endcase
			add_tick(t);
		end
	endtask

	task automatic random_txns(input int budget);
		int r;
		bit lw;
		budget = ticks_made + budget;
		while (ticks_made < budget) begin
			r = $urandom_range(0, 19);
			lw = (gen_tmo < 200) && ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 6)) add_tick('{1'b0, 3'($urandom_range(0, 7)),
						8'($urandom), 1'($urandom_range(0, 1))});
			end
			run_txn(r < 18 ? 3'(r % 6) : 3'(6 + (r & 1)), 8'($urandom),
					$urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0, lw);
		end
	endtask

	// Wait until every result is back and the sequencer has settled
	task automatic drain();
		wait (pending_ticks.size() == 0 && !push && expected_bus.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input int idx, input logic [31:0] val);
		logic [31:0] mask;
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= CFG_AW'(4 * idx); pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0; penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		mask = (idx == 0) ? 32'h00FF_FFFF : 32'h0000_00FF;
		if (prdata !== (val & mask)) begin
			$error("register %0d readback: expected %0h, actual %0h", idx, val & mask, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
		if (idx == 0) begin
			tmo_cfg = val[23:0]; gen_tmo = val[23:0];
		end else begin
			pt_cfg = val[7:0]; gen_pt = val[7:0];
		end
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Request driver: presents the next pending tick once the last one was taken
	always @(negedge clk) begin
		if (arst_n && (!push || in_taken)) begin
			if (pending_ticks.size() != 0 &&
					!((idle_mode == 1 && $urandom_range(0, 99) < 81) ||
					(idle_mode == 3 && $urandom_range(0, 99) < 15))) begin
				drv <= pending_ticks.pop_front();
				push <= 1'b1;
			end else push <= 1'b0;
		end
	end

	// Result side: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_used) begin
				hold_used <= 1'b1;
				hold_left <= HOLD_CYCLES;
				pop <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				pop <= 1'b0;
			end else begin
				pop <= !((idle_mode == 2 && $urandom_range(0, 99) < 81) ||
						(idle_mode == 3 && $urandom_range(0, 99) < 15));
			end
		end
	end

	// Prediction, result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= push && !full;
			if (push && !full) expected_bus.push_back(bus_tick(track_st, tmo_cfg, pt_cfg, drv));
			if (pop && !empty) begin
				results_seen++;
				if (expected_bus.size() == 0) begin
					$error("result with no expectation waiting");
					errors++;
				end else begin
					result_t e;
					e = expected_bus.pop_front();
					check_field("sck_out", e.sck_out, res.sck_out);
					check_field("sda_release", e.sda_release, res.sda_release);
					check_field("busy_res", e.busy_res, res.busy_res);
					check_field("done_res", e.done_res, res.done_res);
					check_field("data_value", e.data_value, res.data_value);
					check_field("ack_error", e.ack_error, res.ack_error);
					check_field("crc_error", e.crc_error, res.crc_error);
					check_field("timeout_error", e.timeout_error, res.timeout_error);
				end
			end
			if ((push && !full) || (pop && !empty)) watchdog <= 0;
			else if (watchdog >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else watchdog <= watchdog + 1;
		end
	end

	// Stimulus phases
	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		push = 1'b0; pop = 1'b0; drv = '0; in_taken = 1'b0;
		track_st = '0; gen_st = '0;
		tmo_cfg = TIMEOUT_RST; gen_tmo = TIMEOUT_RST;
		pt_cfg = PHASE_RST; gen_pt = PHASE_RST;
		idle_mode = 0; hold_req = 1'b0; hold_used = 1'b0; hold_left = 0;
		errors = 0; watchdog = 0; ticks_made = 0; txns_made = 0; results_seen = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every mode, illegal modes, missing ack, bad checksum
		run_txn(MODE_TEMP, 8'h00, 0, 0, 0);
		run_txn(MODE_HUMID, 8'hFF, 0, 0, 0);
		run_txn(MODE_RD_STAT, 8'h00, 0, 0, 0);
		run_txn(MODE_WR_STAT, 8'hFF, 0, 0, 0);
		run_txn(MODE_WR_STAT, 8'h00, 1, 0, 0);
		run_txn(MODE_SOFT_RST, 8'hA5, 0, 0, 0);
		run_txn(MODE_CONN_RST, 8'h5A, 0, 0, 0);
		run_txn(3'd6, 8'hFF, 0, 0, 0);
		run_txn(3'd7, 8'h00, 0, 0, 0);
		run_txn(MODE_RD_STAT, 8'h00, 0, 1, 0);
		run_txn(MODE_TEMP, 8'h00, 1, 1, 0);
		drain();

		// short timeout, zero phase hold (acts as one), sender gaps
		cfg_write(0, 32'd3);
		cfg_write(1, 32'd0);
		idle_mode = 1;
		run_txn(MODE_HUMID, 8'h00, 0, 0, 1);
		random_txns(60);
		drain();

		// zero timeout, receiver stalls and one long hold-off
		cfg_write(0, 32'd0);
		cfg_write(1, 32'd2);
		idle_mode = 2;
		hold_req = 1'b1;
		random_txns(50);
		drain();

		// maximum timeout, both sides idle
		cfg_write(0, 32'hFFFFFF);
		cfg_write(1, 32'd1);
		idle_mode = 3;
		random_txns(60);
		drain();

		cfg_write(0, 32'd40);
		cfg_write(1, 32'd3);
		idle_mode = 0;
		random_txns(30);
		drain();

		// longer phase hold
		cfg_write(1, 32'd4);
		idle_mode = 3;
		run_txn(MODE_CONN_RST, 8'h00, 0, 0, 0);
		drain();
		repeat (10) @(posedge clk);

		$display("Run covered %0d transactions over %0d ticks, %0d results checked,",
				txns_made, ticks_made, results_seen);
		$display("across six register settings and four idle patterns.");
		if (errors == 0 && expected_bus.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/tws_pkg.sv
rtl/core/tws_queue.sv
rtl/core/tws_front.sv
rtl/core/tws_seq.sv
rtl/core/two_wire_sensor_bus_master.sv
tb/sv/tb_top.sv
